/* sv/lbee_pkg.sv */
// Shared types, constants and helpers of the LED brightness effect engine.
`default_nettype none
package lbee_pkg;

    localparam int LEVEL_BITS = 8;
    localparam int TIME_BITS  = 16;
    localparam int DUR_W      = 16;
    localparam int FUNC_W     = 4;
    localparam int DIV_W      = LEVEL_BITS + 1;
    localparam int DIR_W      = 4;
    localparam int FSTEP_W    = 3;

    typedef logic [LEVEL_BITS-1:0] level_t;
    typedef logic [TIME_BITS-1:0]  time_t;
    typedef logic [DUR_W-1:0]      dur_t;
    typedef logic [DIV_W-1:0]      divisor_t;
    typedef logic signed [DIR_W-1:0] dir_t;
    typedef logic [FSTEP_W-1:0]    fstep_t;

    typedef enum logic [2:0] {
        MODE_OFF       = 3'd0,
        MODE_ON        = 3'd1,
        MODE_BREATHE   = 3'd2,
        MODE_FADE_DOWN = 3'd3,
        MODE_FADE_UP   = 3'd4,
        MODE_BLINK     = 3'd5,
        MODE_DIM       = 3'd6
    } mode_t;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK      = 4'd0,
        FN_OFF       = 4'd1,
        FN_ON        = 4'd2,
        FN_BREATHE   = 4'd3,
        FN_FADE_DOWN = 4'd4,
        FN_FADE_UP   = 4'd5,
        FN_BLINK     = 4'd6,
        FN_DIM       = 4'd7,
        FN_RESTART   = 4'd8
    } func_t;

    localparam int REG_MAX_LEVEL = 0;
    localparam int REG_MIN_LEVEL = 1;

    localparam dur_t   PERIOD_ONOFF   = dur_t'(10);
    localparam dur_t   PERIOD_DIM     = dur_t'(1000);
    localparam dur_t   PERIOD_RESET   = dur_t'(30);
    localparam level_t MAX_LEVEL_RST  = level_t'(255);
    localparam level_t MIN_LEVEL_RST  = level_t'(0);
    localparam fstep_t FSTEP_RST      = fstep_t'(5);
    localparam dir_t   DIR_RST        = dir_t'(5);

    typedef struct packed {
        level_t level;
        dir_t   direction;
    } step_t;

    // Clip a duration-sized value to the range of the tick counter.
    function automatic time_t sat_time(input dur_t v);
        localparam int SAT_W = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
        logic [SAT_W-1:0] wide;
        logic [SAT_W-1:0] lim;
        wide = SAT_W'(v);
        lim  = SAT_W'({TIME_BITS{1'b1}});
        if (wide > lim)
            return TIME_BITS'(lim);
        else
            return TIME_BITS'(wide);
    endfunction

endpackage
`default_nettype wire

/* sv/lbee_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module lbee_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire lbee_pkg::dur_t    dividend,
    input  wire lbee_pkg::divisor_t divisor,
    output logic                   done,
    output lbee_pkg::dur_t         quotient
);
    import lbee_pkg::*;

    localparam int CNT_W = $clog2(DUR_W);

    typedef enum logic {DV_IDLE, DV_RUN} dv_state_t;

    dv_state_t          state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    dur_t               q_reg;
    divisor_t           rem_reg;
    divisor_t           dvs_reg;
    logic               done_reg;
    logic [DIV_W:0]     trial;
    logic [DIV_W:0]     diff;
    logic               fits;

    assign trial = {rem_reg, q_reg[DUR_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                DV_IDLE:
                begin
                    if (start)
                    begin
                        q_reg     <= dividend;
                        dvs_reg   <= divisor;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= DV_RUN;
                    end
                end
                DV_RUN:
                begin
                    // The remainder stays below the divisor, so its low bits suffice.
                    rem_reg <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                    q_reg   <= {q_reg[DUR_W-2:0], fits};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DUR_W - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= DV_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

/* sv/lbee_stepper.sv */
// One brightness update step: shared add, clamp and direction reversal.
`default_nettype none
module lbee_stepper (
    input  wire lbee_pkg::mode_t  mode,
    input  wire lbee_pkg::level_t brightness,
    input  wire lbee_pkg::fstep_t fade_step,
    input  wire lbee_pkg::dir_t   fade_dir,
    input  wire lbee_pkg::level_t max_level,
    input  wire lbee_pkg::level_t min_level,
    output lbee_pkg::step_t       result
);
    import lbee_pkg::*;

    localparam int SUM_W = LEVEL_BITS + 2;

    logic signed [SUM_W-1:0] delta;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic signed [SUM_W-1:0] clip;
    level_t                  clamped;
    dir_t                    pos_step;

    assign pos_step = dir_t'({1'b0, fade_step});

    always_comb
    begin
        unique case (mode)
            MODE_BREATHE:   delta = SUM_W'(fade_dir);
            MODE_FADE_DOWN: delta = -$signed(SUM_W'({1'b0, fade_step}));
            MODE_FADE_UP:   delta = $signed(SUM_W'({1'b0, fade_step}));
            default:        delta = '0;
        endcase
        hi   = $signed(SUM_W'({2'b00, max_level}));
        lo   = $signed(SUM_W'({2'b00, min_level}));
        sum  = $signed(SUM_W'({2'b00, brightness})) + delta;
        // The upper bound is applied first, so the lower bound wins when they cross.
        clip = (sum > hi) ? hi : sum;
        clip = (clip < lo) ? lo : clip;
        clamped = clip[LEVEL_BITS-1:0];

        result.level     = brightness;
        result.direction = fade_dir;
        unique case (mode)
            MODE_OFF: result.level = min_level;
            MODE_ON:  result.level = max_level;
            MODE_BREATHE:
            begin
                result.level = clamped;
                if (clamped == min_level)
                    result.direction = pos_step;
                else if (clamped == max_level)
                    result.direction = -pos_step;
            end
            MODE_FADE_DOWN:
                result.level = (clamped == min_level) ? max_level : clamped;
            MODE_FADE_UP:
                result.level = (clamped == max_level) ? min_level : clamped;
            MODE_BLINK:
                result.level = (brightness == max_level) ? min_level : max_level;
            default:
                result.level = brightness;
        endcase
    end

endmodule
`default_nettype wire

/* sv/led_brightness_effect_engine_core.sv */
// Top level of the LED brightness effect engine: sequencer, state and output queue.
// A level that a tick causes goes to the output register, or to the skid entry if held.
// Off, on, blink, dim, restart act on acceptance; input stalls while two levels wait.
// Breathe and fade start the shared divider unless max_level is zero; it retires
// one quotient bit per cycle over the 16-bit duration; its quotient sets the period.
// Reset (rst_n low, asynchronous) gives brightness 127, effect off, period 30.
`default_nettype none
module led_brightness_effect_engine_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [15:0] duration_ms, [23:16] dim_level
    input  wire logic [3:0]  s_tuser,   // [3:0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] level
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_wdata
);
    import lbee_pkg::*;

    typedef enum logic {ST_IDLE, ST_DIV} state_t;

    state_t   state_reg, state_next;
    level_t   max_reg, min_reg;
    level_t   bright_reg, bright_next;
    mode_t    mode_reg, mode_next;
    time_t    period_reg, period_next;
    time_t    elapsed_reg, elapsed_next;
    fstep_t   fstep_reg, fstep_next;
    dir_t     dir_reg, dir_next;

    // Two-entry result queue: the output register plus a skid entry behind it.
    level_t   out_reg, out_next;
    logic     out_valid_reg, out_valid_next;
    level_t   skid_reg, skid_next;
    logic     skid_valid_reg, skid_valid_next;

    logic     s_accept;
    logic     pop;
    logic     push;
    func_t    fn;
    dur_t     dur;
    level_t   dim_val;
    step_t    step;
    logic     div_start;
    divisor_t div_divisor;
    logic     div_done;
    dur_t     div_quot;
    dir_t     one_dir;

    assign dur     = s_tdata[15:0];
    assign dim_val = s_tdata[23:16];
    assign fn      = func_t'(s_tuser);
    assign one_dir = dir_t'(1);

    // New transfers wait while a divide runs or while the skid entry is occupied.
    assign s_tready = (state_reg == ST_IDLE) && !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    lbee_stepper u_stepper (
        .mode       (mode_reg),
        .brightness (bright_reg),
        .fade_step  (fstep_reg),
        .fade_dir   (dir_reg),
        .max_level  (max_reg),
        .min_level  (min_reg),
        .result     (step)
    );

    lbee_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dur),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next   = state_reg;
        bright_next  = bright_reg;
        mode_next    = mode_reg;
        period_next  = period_reg;
        elapsed_next = elapsed_reg;
        fstep_next   = fstep_reg;
        dir_next     = dir_reg;
        div_start    = 1'b0;
        div_divisor  = {1'b0, max_reg};
        push         = 1'b0;

        if (s_accept)
        begin
            unique case (fn)
                FN_TICK:
                begin
                    if (elapsed_reg >= period_reg)
                    begin
                        bright_next  = step.level;
                        dir_next     = step.direction;
                        elapsed_next = '0;
                        push         = 1'b1;
                    end
                    else if (elapsed_reg != {TIME_BITS{1'b1}})
                    begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                end
                FN_OFF:
                begin
                    mode_next   = MODE_OFF;
                    period_next = sat_time(PERIOD_ONOFF);
                end
                FN_ON:
                begin
                    mode_next   = MODE_ON;
                    period_next = sat_time(PERIOD_ONOFF);
                end
                FN_BREATHE:
                begin
                    fstep_next = fstep_t'(1);
                    if (bright_reg == '0)
                        dir_next = one_dir;
                    else if (bright_reg == max_reg)
                        dir_next = -one_dir;
                    mode_next   = MODE_BREATHE;
                    div_divisor = {max_reg, 1'b0};
                    if (max_reg == '0)
                        period_next = sat_time(PERIOD_DIM);
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
                FN_FADE_DOWN:
                begin
                    fstep_next = fstep_t'(1);
                    if (bright_reg == '0)
                        bright_next = max_reg;
                    dir_next  = -one_dir;
                    mode_next = MODE_FADE_DOWN;
                    if (max_reg == '0)
                        period_next = sat_time(PERIOD_DIM);
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
                FN_FADE_UP:
                begin
                    fstep_next = fstep_t'(1);
                    if (bright_reg == max_reg)
                        bright_next = '0;
                    dir_next  = one_dir;
                    mode_next = MODE_FADE_UP;
                    if (max_reg == '0)
                        period_next = sat_time(PERIOD_DIM);
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
                FN_BLINK:
                begin
                    period_next = sat_time({1'b0, dur[DUR_W-1:1]});
                    mode_next   = MODE_BLINK;
                end
                FN_DIM:
                begin
                    mode_next   = MODE_DIM;
                    bright_next = dim_val;
                    period_next = sat_time(PERIOD_DIM);
                end
                FN_RESTART:
                begin
                    bright_next = min_reg;
                end
                default:
                begin
                    // Unused function codes leave the state as it is.
                end
            endcase
        end

        if (state_reg == ST_DIV && div_done)
        begin
            period_next = sat_time(div_quot);
            state_next  = ST_IDLE;
        end
    end

    // Result queue. A push only happens while the skid entry is empty.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = step.level;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = step.level;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            max_reg        <= MAX_LEVEL_RST;
            min_reg        <= MIN_LEVEL_RST;
            bright_reg     <= level_t'(MAX_LEVEL_RST >> 1);
            mode_reg       <= MODE_OFF;
            period_reg     <= sat_time(PERIOD_RESET);
            elapsed_reg    <= '0;
            fstep_reg      <= FSTEP_RST;
            dir_reg        <= DIR_RST;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bright_reg     <= bright_next;
            mode_reg       <= mode_next;
            period_reg     <= period_next;
            elapsed_reg    <= elapsed_next;
            fstep_reg      <= fstep_next;
            dir_reg        <= dir_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == 1'(REG_MAX_LEVEL))
                    max_reg <= cfg_wdata;
                else
                    min_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule
`default_nettype wire
